@@ rtl/core/bounded_value_stack_engine_macros.svh @@
// ----------------------------------------------------------------------------
// bounded_value_stack_engine_macros
// Assertion macros shared by the stack engine RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_VALUE_STACK_ENGINE_MACROS_SVH
`define BOUNDED_VALUE_STACK_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define BVSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property that starts only where a condition holds.
`define BVSE_ASSERT_IF(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Check a property in the cycle after a condition holds.
`define BVSE_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`else
`define BVSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define BVSE_ASSERT_IF(lbl, clk, rst_n, cond, prop, msg)
`define BVSE_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)
`endif

`endif

@@ rtl/core/bvse_pkg.sv @@
// ----------------------------------------------------------------------------
// bvse_pkg
// Types and constants of the bounded value stack engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bvse_pkg;

  // Fixed field widths
  localparam int unsigned FuncW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  // Operation codes carried in func
  typedef enum logic [FuncW-1:0] {
    OP_PUSH = 3'd0,
    OP_DUMP = 3'd1,
    OP_PEEK = 3'd2,
    OP_POP  = 3'd3,
    OP_SWAP = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SHORT = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RESULT,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_C,
    S_DUMP
  } state_e;

endpackage

@@ rtl/core/bvse_stack_mem.sv @@
// ----------------------------------------------------------------------------
// bvse_stack_mem
// Single-port stack memory: one read or one write per cycle, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvse_stack_mem
  import bvse_pkg::*;
#(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  addr_i,
  input  logic [ValueW-1:0] wdata_i,
  output logic [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem_q [Depth];
  logic [ValueW-1:0] rdata_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read the addressed entry; hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/bounded_value_stack_engine.sv @@
// ----------------------------------------------------------------------------
// bounded_value_stack_engine
// Bounded LIFO stack of signed 32-bit values with push, dump, peek, pop, swap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries func_i and push_value_i.
//   Output channel (out_valid_o / out_stall_i) carries value_o, status_o and
//   last_o. A transfer happens on a rising edge with valid high, stall low.
//   One operation is in flight at a time; in_stall_o is high while it runs.
//   Operation steps, from the input transfer, with the receiver ready:
//     push, pop, peek: S_RESULT; swap: S_SWAP_A, S_SWAP_B, S_SWAP_C,
//     S_RESULT (two reads and two writes through the single memory
//     port); dump: S_DUMP, one element read per cycle while the output
//     is not stalled. Unused codes and a dump of an empty stack finish
//     in the transfer cycle with no result.
//   The result reaches the output register as the sequencer leaves
//   S_RESULT for push, pop, peek and swap, and in S_DUMP for each dump
//   element.
//   An output register holds the finished result, so the next input is
//   taken while that result still waits for the receiver.
//   Stalling the output freezes a dump in place; the memory read data
//   holds until the next element is requested.
//   Reset empties the stack at once (count to zero); memory contents are
//   not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_value_stack_engine_macros.svh"

module bounded_value_stack_engine
  import bvse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [FuncW-1:0]          func_i,
  input  logic signed [ValueW-1:0]  push_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ValueW-1:0]  value_o,
  output logic [StatusW-1:0]        status_o,
  output logic                      last_o
);

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntTwo  = CntW'(2);

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic [ValueW-1:0] tmp_q, tmp_d;
  status_e           res_status_q, res_status_d;
  logic              res_rd_q, res_rd_d;

  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;
  logic              out_last_q, out_last_d;

  logic              mem_en, mem_we;
  logic [AddrW-1:0]  mem_addr;
  logic [ValueW-1:0] mem_wdata, mem_rdata;

  logic              out_free, out_load;
  logic [CntW-1:0]   cnt_m1, cnt_m2;
  logic [AddrW-1:0]  top_addr, sec_addr;

  bvse_stack_mem #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Top and second entry addresses
  assign cnt_m1   = count_q - CntOne;
  assign cnt_m2   = count_q - CntTwo;
  assign top_addr = cnt_m1[AddrW-1:0];
  assign sec_addr = cnt_m2[AddrW-1:0];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Sequence the operation through the memory port
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    tmp_d        = tmp_q;
    res_status_d = res_status_q;
    res_rd_d     = res_rd_q;
    mem_en       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = top_addr;
    mem_wdata    = tmp_q;
    out_load     = 1'b0;
    out_value_d  = '0;
    out_status_d = res_status_q;
    out_last_d   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_e'(func_i))
            OP_PUSH: begin
              res_rd_d = 1'b0;
              state_d  = S_RESULT;
              if (count_q == CntFull) begin
                res_status_d = ST_FULL;
              end else begin
                mem_en       = 1'b1;
                mem_we       = 1'b1;
                mem_addr     = count_q[AddrW-1:0];
                mem_wdata    = $unsigned(push_value_i);
                count_d      = count_q + CntOne;
                res_status_d = ST_OK;
              end
            end
            OP_DUMP: begin
              if (count_q != '0) begin
                mem_en   = 1'b1;
                mem_addr = top_addr;
                ptr_d    = top_addr;
                state_d  = S_DUMP;
              end
            end
            OP_PEEK: begin
              state_d = S_RESULT;
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
                res_rd_d     = 1'b0;
              end else begin
                mem_en       = 1'b1;
                mem_addr     = top_addr;
                res_status_d = ST_OK;
                res_rd_d     = 1'b1;
              end
            end
            OP_POP: begin
              res_rd_d = 1'b0;
              state_d  = S_RESULT;
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                count_d      = cnt_m1;
                res_status_d = ST_OK;
              end
            end
            OP_SWAP: begin
              if (count_q < CntTwo) begin
                res_status_d = ST_SHORT;
                res_rd_d     = 1'b0;
                state_d      = S_RESULT;
              end else begin
                mem_en   = 1'b1;
                mem_addr = top_addr;
                state_d  = S_SWAP_A;
              end
            end
            default: begin
              // Drop unused operation codes
            end
          endcase
        end
      end
      S_SWAP_A: begin
        // Hold the top, read the second
        tmp_d    = mem_rdata;
        mem_en   = 1'b1;
        mem_addr = sec_addr;
        state_d  = S_SWAP_B;
      end
      S_SWAP_B: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = top_addr;
        mem_wdata = mem_rdata;
        state_d   = S_SWAP_C;
      end
      S_SWAP_C: begin
        mem_en       = 1'b1;
        mem_we       = 1'b1;
        mem_addr     = sec_addr;
        mem_wdata    = tmp_q;
        res_status_d = ST_OK;
        res_rd_d     = 1'b0;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_value_d  = res_rd_q ? mem_rdata : '0;
          out_status_d = res_status_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_value_d  = mem_rdata;
          out_status_d = ST_OK;
          out_last_d   = (ptr_q == '0);
          if (ptr_q != '0) begin
            mem_en   = 1'b1;
            mem_addr = ptr_q - AddrW'(1);
            ptr_d    = ptr_q - AddrW'(1);
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, clear after transfer
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    tmp_q        <= tmp_d;
    res_status_q <= res_status_d;
    res_rd_q     <= res_rd_d;
    if (out_load) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = $signed(out_value_q);
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  // Assertions
  `BVSE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntFull, "stack count above depth")
  `BVSE_ASSERT_IF(a_dump_ptr, clk_i, rst_ni, state_q == S_DUMP, ptr_q < count_q,
    "dump pointer outside stack")
  `BVSE_ASSERT_NEXT(a_count_hold, clk_i, rst_ni, state_q != S_IDLE, $stable(count_q),
    "stack count moved during an operation")
  `BVSE_ASSERT_IF(a_swap_wr, clk_i, rst_ni, mem_we && (state_q != S_IDLE),
    mem_addr < count_q, "swap write outside stack")

endmodule

@@ verif/bounded_value_stack_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_value_stack_engine_tb
// Self-checking bench for the bounded LIFO stack engine.
// A directed table covers empty, short, full-free corner cases and the
// unused codes. Random phases then fill, drain and mix the stack. Every
// result transfer is checked against an in-bench stack predictor or a
// directed row's expected result. Both channels idle at random, and the
// receiver holds off once for a long stretch while the stack fills.
// ----------------------------------------------------------------------------

module bounded_value_stack_engine_tb
  import bvse_pkg::*;
();

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned RANDOM_OPS = 144;
  localparam int unsigned DIR_ROWS = 26;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Codes of func that the block ignores
  localparam logic [FuncW-1:0] OP_RSVD_A = 3'd5;
  localparam logic [FuncW-1:0] OP_RSVD_B = 3'd6;
  localparam logic [FuncW-1:0] OP_RSVD_C = 3'd7;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_ONE,
    CHK_NONE
  } row_check_e;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } traffic_phase_e;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    status_e                  status;
    logic                     last;
  } stack_result_t;

  typedef struct packed {
    logic [FuncW-1:0]         func;
    logic signed [ValueW-1:0] data;
    row_check_e               chk;
    logic signed [ValueW-1:0] value;
    status_e                  status;
  } dir_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [FuncW-1:0]          func_i = '0;
  logic signed [ValueW-1:0]  push_value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [ValueW-1:0]  value_o;
  logic [StatusW-1:0]        status_o;
  logic                      last_o;

  // Predictor state
  logic signed [ValueW-1:0] stack_words [STACK_DEPTH];
  int unsigned              stack_level = 0;
  stack_result_t            stack_replies_due [$];

  dir_row_t    dir_rows [DIR_ROWS];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_req_count = 0;
  int unsigned hold_seen_count = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_run = 0;

  bounded_value_stack_engine #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .push_value_i(push_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  // Generate the clock
  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Advance the stack predictor by one accepted operation
  function automatic void apply_stack_op(input logic [FuncW-1:0] f,
                                         input logic signed [ValueW-1:0] d,
                                         input bit keep);
    stack_result_t            r;
    logic signed [ValueW-1:0] held;
    int unsigned              k;
    r = '{value: '0, status: ST_OK, last: 1'b1};
    case (f)
      OP_PUSH: begin
        if (stack_level >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_words[stack_level] = d;
          stack_level++;
        end
      end
      OP_DUMP: begin
        for (k = 0; k < stack_level; k++) begin
          r.value = stack_words[stack_level - 1 - k];
          r.last  = (k + 1 == stack_level);
          if (keep) stack_replies_due.push_back(r);
        end
      end
      OP_PEEK: begin
        if (stack_level == 0) r.status = ST_EMPTY;
        else r.value = stack_words[stack_level - 1];
      end
      OP_POP: begin
        if (stack_level == 0) r.status = ST_EMPTY;
        else stack_level--;
      end
      OP_SWAP: begin
        if (stack_level < 2) begin
          r.status = ST_SHORT;
        end else begin
          held = stack_words[stack_level - 1];
          stack_words[stack_level - 1] = stack_words[stack_level - 2];
          stack_words[stack_level - 2] = held;
        end
      end
      default: ;
    endcase
    // Push one result for every operation except dump and unused codes
    if (keep && f != OP_DUMP && f <= OP_SWAP) stack_replies_due.push_back(r);
  endfunction

  // Choose an operation that suits the traffic phase
  function automatic logic [FuncW-1:0] pick_op(input traffic_phase_e ph);
    int unsigned r;
    logic [FuncW-1:0] f;
    r = $urandom_range(0, 19);
    case (ph)
      PH_FILL: begin
        if (r < 14) f = OP_PUSH;
        else if (r < 16) f = OP_PEEK;
        else if (r < 18) f = OP_SWAP;
        else if (r < 19) f = OP_DUMP;
        else f = OP_POP;
      end
      PH_DRAIN: begin
        if (r < 12) f = OP_POP;
        else if (r < 14) f = OP_PEEK;
        else if (r < 16) f = OP_SWAP;
        else if (r < 17) f = OP_DUMP;
        else f = OP_PUSH;
      end
      default: begin
        if (r == 0) f = FuncW'($urandom_range(OP_RSVD_A, OP_RSVD_C));
        else f = FuncW'($urandom_range(OP_PUSH, OP_SWAP));
      end
    endcase
    return f;
  endfunction

  // Draw a value, leaning on the signed extremes
  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned r;
    logic signed [ValueW-1:0] v;
    r = $urandom_range(0, 9);
    case (r)
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h0000_0000;
      3: v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offer one operation and hold it until the transfer
  task automatic offer_op(input logic [FuncW-1:0] f, input logic signed [ValueW-1:0] d);
    in_valid_i   <= 1'b1;
    func_i       <= f;
    push_value_i <= d;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  // Idle the input side for a random gap, mostly short
  task automatic pause_sender();
    int unsigned n;
    int unsigned r;
    n = 0;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 19);
      if (r < 9) n = 0;
      else if (r < 17) n = $urandom_range(1, 3);
      else if (r < 19) n = $urandom_range(8, 30);
      else burst_left = $urandom_range(15, 40);
    end
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Wait with the input idle until every outstanding result has arrived
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (stack_replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_field(input string field, input logic [ValueW-1:0] want,
                              input logic [ValueW-1:0] got);
    mismatch_count++;
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  // Check result transfers and drive the output stall
  always @(posedge clk_i) begin : rx_side
    stack_result_t want;
    int unsigned   r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (stack_replies_due.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected result, expected none, actual value %h status %0d last %b",
                   $time, value_o, status_o, last_o);
        end else begin
          want = stack_replies_due.pop_front();
          if (value_o !== want.value) report_field("value", want.value, value_o);
          if (status_o !== want.status) begin
            report_field("status", ValueW'(want.status), ValueW'(status_o));
          end
          if (last_o !== want.last) begin
            report_field("last", ValueW'(want.last), ValueW'(last_o));
          end
        end
      end
      // Start the long hold-off on request, else draw a new stall pattern
      if (hold_seen_count != hold_req_count) begin
        hold_seen_count = hold_req_count;
        rx_wait = LONG_HOLD;
        rx_run = 1;
      end else if (rx_wait == 0 && rx_run == 0) begin
        r = $urandom_range(0, 19);
        if (r < 8) rx_wait = 0;
        else if (r < 17) rx_wait = $urandom_range(1, 3);
        else rx_wait = $urandom_range(10, 40);
        rx_run = (r == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      end
      if (rx_wait != 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
        if (rx_run != 0) rx_run--;
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Drive reset and all stimulus
  initial begin : stimulus
    dir_row_t                 row;
    traffic_phase_e           phase;
    logic [FuncW-1:0]         f;
    logic signed [ValueW-1:0] d;
    int unsigned              ops_done;
    int unsigned              phase_items;
    int unsigned              phase_len;
    int unsigned              edge_hits;
    int unsigned              r;
    bit                       first_phase;
    bit                       paused;
    bit                       phase_open;

    dir_rows = '{
      '{OP_PEEK,   32'h0000_0000, CHK_ONE,   32'h0000_0000, ST_EMPTY},
      '{OP_POP,    32'h0000_0000, CHK_ONE,   32'h0000_0000, ST_EMPTY},
      '{OP_SWAP,   32'h0000_0000, CHK_ONE,   32'h0000_0000, ST_SHORT},
      '{OP_DUMP,   32'h0000_0000, CHK_NONE,  32'h0000_0000, ST_OK},
      '{OP_RSVD_A, 32'h7FFF_FFFF, CHK_NONE,  32'h0000_0000, ST_OK},
      '{OP_RSVD_B, 32'h8000_0000, CHK_NONE,  32'h0000_0000, ST_OK},
      '{OP_RSVD_C, 32'hFFFF_FFFF, CHK_NONE,  32'h0000_0000, ST_OK},
      '{OP_PUSH,   32'h7FFF_FFFF, CHK_ONE,   32'h0000_0000, ST_OK},
      '{OP_SWAP,   32'h0000_0000, CHK_ONE,   32'h0000_0000, ST_SHORT},
      '{OP_PEEK,   32'h0000_0000, CHK_ONE,   32'h7FFF_FFFF, ST_OK},
      '{OP_PUSH,   32'h8000_0000, CHK_ONE,   32'h0000_0000, ST_OK},
      '{OP_PEEK,   32'h1234_5678, CHK_ONE,   32'h8000_0000, ST_OK},
      '{OP_SWAP,   32'hFFFF_FFFF, CHK_MODEL, 32'h0000_0000, ST_OK},
      '{OP_PEEK,   32'h0000_0000, CHK_MODEL, 32'h0000_0000, ST_OK},
      '{OP_DUMP,   32'h0000_0000, CHK_MODEL, 32'h0000_0000, ST_OK},
      '{OP_PUSH,   32'h0000_0000, CHK_MODEL, 32'h0000_0000, ST_OK},
      '{OP_PUSH,   32'hFFFF_FFFF, CHK_MODEL, 32'h0000_0000, ST_OK},
      '{OP_RSVD_A, 32'h0000_0000, CHK_NONE,  32'h0000_0000, ST_OK},
      '{OP_DUMP,   32'h0000_0000, CHK_MODEL, 32'h0000_0000, ST_OK},
      '{OP_POP,    32'h0000_0000, CHK_MODEL, 32'h0000_0000, ST_OK},
      '{OP_POP,    32'h0000_0000, CHK_MODEL, 32'h0000_0000, ST_OK},
      '{OP_SWAP,   32'h0000_0000, CHK_MODEL, 32'h0000_0000, ST_OK},
      '{OP_POP,    32'h0000_0000, CHK_MODEL, 32'h0000_0000, ST_OK},
      '{OP_POP,    32'h0000_0000, CHK_MODEL, 32'h0000_0000, ST_OK},
      '{OP_POP,    32'h0000_0000, CHK_ONE,   32'h0000_0000, ST_EMPTY},
      '{OP_DUMP,   32'h0000_0000, CHK_NONE,  32'h0000_0000, ST_OK}
    };

    // Hold reset, then release it on a clock edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      offer_op(row.func, row.data);
      case (row.chk)
        CHK_MODEL: apply_stack_op(row.func, row.data, 1'b1);
        CHK_ONE: begin
          apply_stack_op(row.func, row.data, 1'b0);
          stack_replies_due.push_back('{value: row.value, status: row.status, last: 1'b1});
        end
        default: apply_stack_op(row.func, row.data, 1'b0);
      endcase
      pause_sender();
    end

    // Run random phases: the first fills the stack under a long hold-off
    ops_done = 0;
    first_phase = 1'b1;
    paused = 1'b0;
    while (ops_done < RANDOM_OPS) begin
      if (first_phase) begin
        phase = PH_FILL;
        hold_req_count <= hold_req_count + 1;
        first_phase = 1'b0;
      end else begin
        r = $urandom_range(0, 9);
        phase = (r < 3) ? PH_FILL : (r < 6) ? PH_DRAIN : PH_MIX;
      end
      phase_items = 0;
      edge_hits = 0;
      phase_len = $urandom_range(15, 30);
      phase_open = 1'b1;
      while (phase_open) begin
        f = pick_op(phase);
        d = pick_value();
        if ((f == OP_PUSH && stack_level == STACK_DEPTH) ||
            (f == OP_POP && stack_level == 0)) edge_hits++;
        offer_op(f, d);
        apply_stack_op(f, d, 1'b1);
        pause_sender();
        if (f <= OP_SWAP) ops_done++;
        phase_items++;
        // Pause the sender once until the output side catches up
        if (!paused && ops_done >= RANDOM_OPS / 2) begin
          paused = 1'b1;
          drain_results();
        end
        case (phase)
          PH_FILL:
            phase_open = !(stack_level == STACK_DEPTH && edge_hits >= 2) && phase_items < 90;
          PH_DRAIN:
            phase_open = !(stack_level == 0 && edge_hits >= 2) && phase_items < 90;
          default:
            phase_open = phase_items < phase_len;
        endcase
        if (ops_done >= RANDOM_OPS) phase_open = 1'b0;
      end
    end

    // Drain, let the block settle, then report
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/bvse_pkg.sv
rtl/core/bvse_stack_mem.sv
rtl/core/bounded_value_stack_engine.sv
verif/bounded_value_stack_engine_tb.sv
